FILE: sv/two_beam_direction_counter_defines.svh
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef TWO_BEAM_DIRECTION_COUNTER_DEFINES_SVH
`define TWO_BEAM_DIRECTION_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define TBDC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbdc check failed");

// Next-cycle implication.
`define TBDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbdc check failed");

`endif

FILE: sv/tbdc_pkg.sv
package tbdc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int TIME_BITS  = 32;

	localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
	localparam logic [15:0] COOLDOWN_RESET = 16'd300;

	localparam int ADDR_BITS = 3;
	localparam logic REG_TIMEOUT  = 1'b0;
	localparam logic REG_COOLDOWN = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_OUTER = 2'd1,
		PH_INNER = 2'd2
	} phase_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        outer_level;
		logic        inner_level;
	} sample_t;

	typedef struct packed {
		logic [15:0] occupant_count;
		logic [15:0] entry_total;
		logic [15:0] exit_total;
		logic        entry_seen;
		logic        exit_seen;
		logic [1:0]  phase_now;
	} result_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [15:0] cooldown_ms;
	} cfg_t;

endpackage

FILE: sv/tbdc_cfg.sv
module tbdc_cfg import tbdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	logic [15:0] timeout_q;
	logic [15:0] cooldown_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			cooldown_q <= COOLDOWN_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
				REG_COOLDOWN: cooldown_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TIMEOUT:  prdata = {16'd0, timeout_q};
			REG_COOLDOWN: prdata = {16'd0, cooldown_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg.timeout_ms  = timeout_q;
	assign cfg.cooldown_ms = cooldown_q;

endmodule

FILE: sv/tbdc_core.sv
module tbdc_core import tbdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  sample_t sample_s1,
	output result_t result_q
);

	phase_t                phase_q, phase_d;
	logic                  prev_outer_q, prev_outer_d;
	logic                  prev_inner_q, prev_inner_d;
	logic [TIME_BITS-1:0]  arm_time_q, arm_time_d;
	logic [TIME_BITS-1:0]  pass_time_q, pass_time_d;
	logic [COUNT_BITS-1:0] occupants_q, occupants_d;
	logic [COUNT_BITS-1:0] entries_q, entries_d;
	logic [COUNT_BITS-1:0] exits_q, exits_d;

	logic [TIME_BITS-1:0]  now;
	logic [TIME_BITS-1:0]  since_pass;
	logic [TIME_BITS-1:0]  since_arm;
	logic                  live;
	logic                  outer_edge;
	logic                  inner_edge;
	logic                  expired;
	logic                  got_entry;
	logic                  got_exit;

	assign now        = TIME_BITS'(sample_s1.now_ms);
	assign since_pass = now - pass_time_q;
	assign since_arm  = now - arm_time_q;
	assign live       = since_pass >= TIME_BITS'(cfg.cooldown_ms);
	assign outer_edge = !sample_s1.outer_level && prev_outer_q;
	assign inner_edge = !sample_s1.inner_level && prev_inner_q;
	assign expired    = since_arm > TIME_BITS'(cfg.timeout_ms);

	always_comb begin
		phase_d      = phase_q;
		prev_outer_d = prev_outer_q;
		prev_inner_d = prev_inner_q;
		arm_time_d   = arm_time_q;
		pass_time_d  = pass_time_q;
		occupants_d  = occupants_q;
		entries_d    = entries_q;
		exits_d      = exits_q;
		got_entry    = 1'b0;
		got_exit     = 1'b0;
		// inside the cooldown window the sample is dropped, levels included
		if (live) begin
			prev_outer_d = sample_s1.outer_level;
			prev_inner_d = sample_s1.inner_level;
			case (phase_q)
				PH_OUTER: begin
					if (inner_edge) begin
						if (occupants_q != '1) occupants_d = occupants_q + 1'b1;
						if (entries_q != '1)   entries_d   = entries_q + 1'b1;
						pass_time_d = now;
						phase_d     = PH_IDLE;
						got_entry   = 1'b1;
					end else if (expired) begin
						phase_d = PH_IDLE;
					end
				end
				PH_INNER: begin
					if (outer_edge) begin
						// floor at zero, but still count the exit
						if (occupants_q != '0) occupants_d = occupants_q - 1'b1;
						if (exits_q != '1)     exits_d     = exits_q + 1'b1;
						pass_time_d = now;
						phase_d     = PH_IDLE;
						got_exit    = 1'b1;
					end else if (expired) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					if (outer_edge) begin
						phase_d    = PH_OUTER;
						arm_time_d = now;
					end else if (inner_edge) begin
						phase_d    = PH_INNER;
						arm_time_d = now;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			prev_outer_q <= 1'b1;
			prev_inner_q <= 1'b1;
			arm_time_q   <= '0;
			pass_time_q  <= '0;
			occupants_q  <= '0;
			entries_q    <= '0;
			exits_q      <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			prev_outer_q <= prev_outer_d;
			prev_inner_q <= prev_inner_d;
			arm_time_q   <= arm_time_d;
			pass_time_q  <= pass_time_d;
			occupants_q  <= occupants_d;
			entries_q    <= entries_d;
			exits_q      <= exits_d;
		end
	end

	// result word: payload only, no reset
	always_ff @(posedge clk) begin
		if (step) begin
			result_q.occupant_count <= 16'(occupants_d);
			result_q.entry_total    <= 16'(entries_d);
			result_q.exit_total     <= 16'(exits_d);
			result_q.entry_seen     <= got_entry;
			result_q.exit_seen      <= got_exit;
			result_q.phase_now      <= phase_d;
		end
	end

endmodule

FILE: sv/two_beam_direction_counter.sv
// channel   direction  handshake                     word
// sample    in         sample_valid / sample_stall   sample_t (now_ms, outer, inner)
// result    out        result_valid / result_stall   result_t (counts, seen flags, phase)
// config    in         APB psel/penable/pwrite       timeout_ms @0x0, cooldown_ms @0x4
//
// One sample word per cycle sustained unless the result is held; each word goes to the
// input register, then through the step logic into the result register.
// The step is one pass over phase, edge and counter registers, so the next word
// sees this one's state at once. Reset clears phase and counters, sets last levels high.
// A held result stalls the sample side only when the input register is also full.
`include "two_beam_direction_counter_defines.svh"

module two_beam_direction_counter import tbdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	cfg_t    cfg;
	logic    valid_s1;
	sample_t sample_s1;
	logic    result_valid_q;
	logic    out_free;
	logic    step;

	assign out_free     = !result_valid_q || !result_stall;
	assign step         = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!sample_stall) valid_s1 <= sample_valid;
			if (out_free) result_valid_q <= valid_s1;
		end
	end

	// hold the word while the stage is stalled
	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) sample_s1 <= sample;
	end

	tbdc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tbdc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.sample_s1 (sample_s1),
		.result_q  (result)
	);

	`TBDC_ASSERT_NOW(a_stall_only_when_full, sample_stall, valid_s1 && result_valid_q)
	`TBDC_ASSERT_NEXT(a_step_gives_result, step, result_valid_q)
	`TBDC_ASSERT_NOW(a_pass_returns_idle,
		result_valid_q && (result.entry_seen || result.exit_seen),
		result.phase_now == PH_IDLE)
	`TBDC_ASSERT_NOW(a_entry_counted, result_valid_q && result.entry_seen,
		result.entry_total != 16'd0)

endmodule
